### rtl/hrle_pkg.sv
// Shared types and constants for the HTTP request line extractor.
// No dependencies; imported by the parser, the emitter, the top level and the bench.
package hrle_pkg;

  localparam int METHOD_CHARS_DEF = 16;
  localparam int PATH_CHARS_DEF   = 64;
  localparam int NUM_RECORDS      = 8;

  localparam logic [15:0] ETH_TYPE_IP  = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_NUL       = 8'h00;
  localparam logic [31:0] HTTP_WORD    = 32'h48545450;  // "HTTP"

  localparam logic [15:0] POS_TYPE_HI = 16'd12;
  localparam logic [15:0] POS_TYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL     = 16'd14;
  localparam logic [15:0] POS_PROTO   = 16'd23;
  localparam logic [15:0] POS_SRC_LO  = 16'd26;
  localparam logic [15:0] POS_SRC_HI  = 16'd29;
  localparam logic [15:0] POS_DST_LO  = 16'd30;
  localparam logic [15:0] POS_DST_HI  = 16'd33;
  localparam logic [15:0] TCP_DOFF_OFS = 16'd12;

  // store write port, driven by the parser
  typedef struct packed {
    logic       m_we;
    logic       p_we;
    logic       bank;
    logic [7:0] data;
  } hrle_wr_t;

  // run start, handed from parser to emitter on an accepted frame
  typedef struct packed {
    logic        valid;
    logic        bank;
    logic [31:0] src;
    logic [31:0] dst;
    logic [63:0] stamp;
  } hrle_run_t;

  function automatic logic [7:0] http_char(input logic [1:0] idx);
    return HTTP_WORD[{~idx, 3'b000} +: 8];
  endfunction

endpackage

### rtl/hrle_store.sv
// Two-bank character store, rows of eight bytes, byte-wide writes.
// Depends on nothing but its parameters; one instance for method, one for path.
module hrle_store #(
  parameter int CHARS = 16,
  parameter int CW    = $clog2(CHARS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          wbank,
  input  logic [CW-1:0] wcnt,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic          rbank,
  input  logic [2:0]    rk,
  output logic [63:0]   rdata
);

  localparam int ROWS  = (CHARS + 7) / 8;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = 2 << RAW;

  logic [63:0]  mem_r [DEPTH];
  logic [RAW:0] waddr;
  logic [RAW:0] raddr;

  assign waddr = {wbank, RAW'(wcnt >> 3)};
  assign raddr = {rbank, RAW'(rk)};

  // first character of a row sits in the top byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr][{~wcnt[2:0], 3'b000} +: 8] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/hrle_parser.sv
// Per-byte header checks and request line capture for one frame at a time.
// Depends on hrle_pkg; drives the store write port and the emitter start.
module hrle_parser #(
  parameter int METHOD_CHARS = hrle_pkg::METHOD_CHARS_DEF,
  parameter int PATH_CHARS   = hrle_pkg::PATH_CHARS_DEF,
  parameter int MCW          = $clog2(METHOD_CHARS),
  parameter int PCW          = $clog2(PATH_CHARS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic [63:0]        in_time,
  output hrle_pkg::hrle_wr_t wr,
  output logic [MCW-1:0]     mcnt,
  output logic [PCW-1:0]     pcnt,
  output hrle_pkg::hrle_run_t run
);
  import hrle_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_METHOD,
    PH_PATH,
    PH_HTTP,
    PH_ACCEPT
  } phase_t;

  phase_t         phase_r, phase_nxt, ph;
  logic [15:0]    pos_r, pos_nxt;
  logic           ok_r, ok_nxt;
  logic [6:0]     tcp_r, tcp_nxt;
  logic [7:0]     pay_r, pay_nxt;
  logic [MCW-1:0] mcnt_r, mcnt_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [1:0]     match_r, match_nxt;
  logic [31:0]    src_r, src_nxt;
  logic [31:0]    dst_r, dst_nxt;
  logic [63:0]    time_r, time_nxt;
  logic           bank_r, bank_nxt;
  logic           m_we, p_we, done;

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    ok_nxt    = ok_r;
    tcp_nxt   = tcp_r;
    pay_nxt   = pay_r;
    mcnt_nxt  = mcnt_r;
    pcnt_nxt  = pcnt_r;
    match_nxt = match_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    time_nxt  = time_r;
    bank_nxt  = bank_r;
    m_we      = 1'b0;
    p_we      = 1'b0;
    done      = 1'b0;
    ph = (phase_r == PH_HEADER && pay_r != '0 && pos_r == 16'(pay_r)) ? PH_METHOD : phase_r;
    if (in_fire) begin
      if (pos_r == '0) time_nxt = in_time;
      if (ok_r) begin
        phase_nxt = ph;
        unique case (ph)
          PH_HEADER: begin
            if (pos_r == POS_TYPE_HI && in_byte != ETH_TYPE_IP[15:8]) ok_nxt = 1'b0;
            if (pos_r == POS_TYPE_LO && in_byte != ETH_TYPE_IP[7:0]) ok_nxt = 1'b0;
            if (pos_r == POS_IHL) begin
              if (in_byte[3:0] < MIN_HDR_WORDS) ok_nxt = 1'b0;
              else tcp_nxt = 7'(8'(POS_IHL) + {2'b00, in_byte[3:0], 2'b00});
            end
            if (pos_r == POS_PROTO && in_byte != IP_PROTO_TCP) ok_nxt = 1'b0;
            if (pos_r >= POS_SRC_LO && pos_r <= POS_SRC_HI) src_nxt = {src_r[23:0], in_byte};
            if (pos_r >= POS_DST_LO && pos_r <= POS_DST_HI) dst_nxt = {dst_r[23:0], in_byte};
            if (tcp_r != '0 && pos_r == 16'(tcp_r) + TCP_DOFF_OFS) begin
              if (in_byte[7:4] < MIN_HDR_WORDS) ok_nxt = 1'b0;
              else pay_nxt = 8'(tcp_r) + {2'b00, in_byte[7:4], 2'b00};
            end
          end
          PH_METHOD: begin
            if (mcnt_r < MCW'(METHOD_CHARS - 1) && in_byte != CH_SPACE) begin
              m_we     = 1'b1;
              mcnt_nxt = mcnt_r + 1'b1;
            end else begin
              phase_nxt = PH_PATH;
            end
          end
          PH_PATH: begin
            if (pcnt_r < PCW'(PATH_CHARS - 1) && in_byte != CH_SPACE && in_byte != CH_NUL) begin
              p_we     = 1'b1;
              pcnt_nxt = pcnt_r + 1'b1;
            end else begin
              phase_nxt = PH_HTTP;
              match_nxt = '0;
            end
          end
          PH_HTTP: begin
            if (in_byte != http_char(match_r)) ok_nxt = 1'b0;
            else if (match_r == 2'd3) phase_nxt = PH_ACCEPT;
            else match_nxt = match_r + 1'b1;
          end
          PH_ACCEPT: ;
          default: ;
        endcase
      end
      if (in_last) begin
        done      = ok_nxt && (phase_nxt == PH_ACCEPT);
        if (done) bank_nxt = ~bank_r;
        pos_nxt   = '0;
        phase_nxt = PH_HEADER;
        ok_nxt    = 1'b1;
        tcp_nxt   = '0;
        pay_nxt   = '0;
        mcnt_nxt  = '0;
        pcnt_nxt  = '0;
        match_nxt = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
      end else if (pos_r != 16'hFFFF) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      ok_r    <= 1'b1;
      tcp_r   <= '0;
      pay_r   <= '0;
      mcnt_r  <= '0;
      pcnt_r  <= '0;
      match_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      time_r  <= '0;
      bank_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      ok_r    <= ok_nxt;
      tcp_r   <= tcp_nxt;
      pay_r   <= pay_nxt;
      mcnt_r  <= mcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      match_r <= match_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      time_r  <= time_nxt;
      bank_r  <= bank_nxt;
    end
  end

  assign wr.m_we   = m_we;
  assign wr.p_we   = p_we;
  assign wr.bank   = bank_r;
  assign wr.data   = in_byte;
  assign mcnt      = mcnt_r;
  assign pcnt      = pcnt_r;
  assign run.valid = done;
  assign run.bank  = bank_r;
  assign run.src   = src_r;
  assign run.dst   = dst_r;
  assign run.stamp = time_r;

  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ACCEPT |-> ok_r)
    else $error("accept phase with failed header");
  a_mcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= MCW'(METHOD_CHARS - 1))
    else $error("method count overrun");
  a_pcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCW'(PATH_CHARS - 1))
    else $error("path count overrun");

endmodule

### rtl/hrle_emitter.sv
// Record sequencer: eight store reads per accepted frame, masked by count,
// through a read stage and an output register. Depends on hrle_pkg.
module hrle_emitter #(
  parameter int METHOD_CHARS = hrle_pkg::METHOD_CHARS_DEF,
  parameter int PATH_CHARS   = hrle_pkg::PATH_CHARS_DEF,
  parameter int MCW          = $clog2(METHOD_CHARS),
  parameter int PCW          = $clog2(PATH_CHARS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hrle_pkg::hrle_run_t run,
  input  logic [MCW-1:0]      mcnt,
  input  logic [PCW-1:0]      pcnt,
  output logic                busy,
  output logic                rd_en,
  output logic                rd_bank,
  output logic [2:0]          rd_k,
  input  logic [63:0]         m_rdata,
  input  logic [63:0]         p_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_src,
  output logic [31:0]         out_dst,
  output logic [63:0]         out_stamp,
  output logic [2:0]          out_k,
  output logic [63:0]         out_method,
  output logic [63:0]         out_path,
  output logic                out_last
);
  import hrle_pkg::*;

  localparam int CMPW = ((MCW > PCW) ? MCW : PCW) + 6;

  logic           busy_r;
  logic [3:0]     iss_r;
  logic           s1_v_r;
  logic [2:0]     s1_k_r;
  logic           out_v_r;
  logic           bank_r;
  logic [31:0]    src_r, dst_r;
  logic [63:0]    stamp_r;
  logic [MCW-1:0] mcnt_r;
  logic [PCW-1:0] pcnt_r;
  logic [31:0]    o_src_r, o_dst_r;
  logic [63:0]    o_stamp_r, o_m_r, o_p_r;
  logic [2:0]     o_k_r;
  logic           out_free, move, issue;
  logic [63:0]    m_mask, p_mask;

  assign out_free = !out_v_r || out_ready;
  assign move     = s1_v_r && out_free;
  assign issue    = busy_r && !iss_r[3] && (!s1_v_r || out_free);

  always_comb begin
    for (int c = 0; c < NUM_RECORDS; c++) begin
      m_mask[63 - 8 * c -: 8] = (CMPW'({s1_k_r, 3'(c)}) < CMPW'(mcnt_r)) ?
                                m_rdata[63 - 8 * c -: 8] : 8'h00;
      p_mask[63 - 8 * c -: 8] = (CMPW'({s1_k_r, 3'(c)}) < CMPW'(pcnt_r)) ?
                                p_rdata[63 - 8 * c -: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      iss_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (run.valid) begin
        busy_r <= 1'b1;
        iss_r  <= '0;
      end
      if (issue) begin
        iss_r  <= iss_r + 1'b1;
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
        if (s1_k_r == 3'(NUM_RECORDS - 1)) busy_r <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run.valid) begin
      bank_r  <= run.bank;
      src_r   <= run.src;
      dst_r   <= run.dst;
      stamp_r <= run.stamp;
      mcnt_r  <= mcnt;
      pcnt_r  <= pcnt;
    end
    if (issue) s1_k_r <= iss_r[2:0];
    if (move) begin
      o_src_r   <= src_r;
      o_dst_r   <= dst_r;
      o_stamp_r <= stamp_r;
      o_k_r     <= s1_k_r;
      o_m_r     <= m_mask;
      o_p_r     <= p_mask;
    end
  end

  assign busy       = busy_r;
  assign rd_en      = issue;
  assign rd_bank    = bank_r;
  assign rd_k       = iss_r[2:0];
  assign out_valid  = out_v_r;
  assign out_src    = o_src_r;
  assign out_dst    = o_dst_r;
  assign out_stamp  = o_stamp_r;
  assign out_k      = o_k_r;
  assign out_method = o_m_r;
  assign out_path   = o_p_r;
  assign out_last   = (o_k_r == 3'(NUM_RECORDS - 1));

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    run.valid |-> !busy_r)
    else $error("run started while previous run active");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !s1_v_r)
    else $error("read stage holds data while idle");
  a_iss_range: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= 4'(NUM_RECORDS))
    else $error("issue count overrun");

endmodule

### rtl/http_request_line_extractor.sv
// Top level of the HTTP request line extractor.
// Depends on hrle_pkg, hrle_parser, hrle_store and hrle_emitter.
//
// Usage:
//   Input stream carries one Ethernet frame byte per transfer; in_tlast marks
//   the final byte, and the time in in_tdata is latched on the first byte.
//   Headers are checked and the request line captured as the bytes go by, one
//   byte per cycle with no bubbles while in_tready is high.
//   When the last byte of a frame with a valid IPv4/TCP header and an HTTP
//   request line arrives, eight records go out on the output stream, the
//   eighth flagged by out_tlast. Rejected frames produce nothing.
//   The last-byte transfer reaches the output through the emitter's busy flag,
//   the store read and the output register; the run then sustains one record
//   per cycle while out_tready is high, set by the one store read per record.
//   The next frame's bytes are taken while a run drains; only a last byte is
//   held off (in_tready low) until the previous run has left the read stage.
//   A stalled out_tready holds the current record and backs up the run.
//   Reset clears all frame state; the character stores need no clearing.
module http_request_line_extractor #(
  parameter int METHOD_CHARS = hrle_pkg::METHOD_CHARS_DEF,
  parameter int PATH_CHARS   = hrle_pkg::PATH_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // pkt_byte[7:0], arrival_time[71:8]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata,  // src_addr[31:0], dst_addr[63:32], stamp[127:64],
                                   // chunk_index[130:128], method_chunk[194:131],
                                   // path_chunk[258:195], zero pad[263:259]
  output logic         out_tlast
);
  import hrle_pkg::*;

  localparam int MCW = $clog2(METHOD_CHARS);
  localparam int PCW = $clog2(PATH_CHARS);

  hrle_wr_t       wr;
  hrle_run_t      run;
  logic [MCW-1:0] mcnt;
  logic [PCW-1:0] pcnt;
  logic           busy, rd_en, rd_bank;
  logic [2:0]     rd_k;
  logic [63:0]    m_rdata, p_rdata;
  logic           in_fire;
  logic [31:0]    o_src, o_dst;
  logic [63:0]    o_stamp, o_m, o_p;
  logic [2:0]     o_k;

  assign in_tready = !(in_tlast && busy);
  assign in_fire   = in_tvalid && in_tready;

  hrle_parser #(
    .METHOD_CHARS(METHOD_CHARS),
    .PATH_CHARS  (PATH_CHARS),
    .MCW         (MCW),
    .PCW         (PCW)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_byte(in_tdata[7:0]),
    .in_last(in_tlast),
    .in_time(in_tdata[71:8]),
    .wr     (wr),
    .mcnt   (mcnt),
    .pcnt   (pcnt),
    .run    (run)
  );

  hrle_store #(
    .CHARS(METHOD_CHARS),
    .CW   (MCW)
  ) u_mstore (
    .clk  (clk),
    .we   (wr.m_we),
    .wbank(wr.bank),
    .wcnt (mcnt),
    .wdata(wr.data),
    .re   (rd_en),
    .rbank(rd_bank),
    .rk   (rd_k),
    .rdata(m_rdata)
  );

  hrle_store #(
    .CHARS(PATH_CHARS),
    .CW   (PCW)
  ) u_pstore (
    .clk  (clk),
    .we   (wr.p_we),
    .wbank(wr.bank),
    .wcnt (pcnt),
    .wdata(wr.data),
    .re   (rd_en),
    .rbank(rd_bank),
    .rk   (rd_k),
    .rdata(p_rdata)
  );

  hrle_emitter #(
    .METHOD_CHARS(METHOD_CHARS),
    .PATH_CHARS  (PATH_CHARS),
    .MCW         (MCW),
    .PCW         (PCW)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .run       (run),
    .mcnt      (mcnt),
    .pcnt      (pcnt),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_bank   (rd_bank),
    .rd_k      (rd_k),
    .m_rdata   (m_rdata),
    .p_rdata   (p_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_src   (o_src),
    .out_dst   (o_dst),
    .out_stamp (o_stamp),
    .out_k     (o_k),
    .out_method(o_m),
    .out_path  (o_p),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b00000, o_p, o_m, o_k, o_stamp, o_dst, o_src};

endmodule

### tb/http_request_line_extractor_tb.sv
// Self-checking bench for http_request_line_extractor: Ethernet/IPv4/TCP frames
// go in one byte per transfer and each record coming out is checked against a
// byte-level request line parser kept here. Depends on hrle_pkg and the RTL.
module http_request_line_extractor_tb;
  import hrle_pkg::*;

  localparam int METHOD_CHARS = METHOD_CHARS_DEF;
  localparam int PATH_CHARS   = PATH_CHARS_DEF;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [31:0] VERSION_TAG = HTTP_WORD;

  typedef enum logic [2:0] {
    SCAN_HEADER, SCAN_METHOD, SCAN_PATH, SCAN_VERSION, SCAN_DONE
  } scan_phase_t;

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic [63:0] stamp;
    logic [2:0]  index;
    logic [63:0] method;
    logic [63:0] path;
    logic        last;
  } http_record_t;

  class request_line_scoreboard;
    logic [15:0]  pos;
    scan_phase_t  phase;
    bit           hdr_ok;
    logic [3:0]   ihl;
    logic [15:0]  tcp_at;
    logic [15:0]  payload_at;
    logic [7:0]   method_chars [METHOD_CHARS];
    int unsigned  n_method;
    logic [7:0]   path_chars [PATH_CHARS];
    int unsigned  n_path;
    logic [2:0]   tag_matched;
    logic [31:0]  src;
    logic [31:0]  dst;
    logic [63:0]  stamp;
    http_record_t expected_records[$];
    int unsigned  errors;
    int unsigned  records_checked;
    int unsigned  records_predicted;

    function new();
      clear_frame();
      stamp = '0;
      errors = 0;
      records_checked = 0;
      records_predicted = 0;
    endfunction

    function void clear_frame();
      pos = '0;
      phase = SCAN_HEADER;
      hdr_ok = 1'b1;
      ihl = '0;
      tcp_at = '0;
      payload_at = '0;
      foreach (method_chars[i]) method_chars[i] = '0;
      foreach (path_chars[i]) path_chars[i] = '0;
      n_method = 0;
      n_path = 0;
      tag_matched = '0;
      src = '0;
      dst = '0;
    endfunction

    function void header_byte(input logic [7:0] b);
      logic [3:0] doff;
      if (pos == POS_TYPE_HI && b != ETH_TYPE_IP[15:8]) hdr_ok = 1'b0;
      if (pos == POS_TYPE_LO && b != ETH_TYPE_IP[7:0]) hdr_ok = 1'b0;
      if (pos == POS_IHL) begin
        ihl = b[3:0];
        if (ihl < MIN_HDR_WORDS) hdr_ok = 1'b0;
        else tcp_at = POS_IHL + 16'(ihl) * 16'd4;
      end
      if (pos == POS_PROTO && b != IP_PROTO_TCP) hdr_ok = 1'b0;
      if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) src = {src[23:0], b};
      if (pos >= POS_DST_LO && pos <= POS_DST_HI) dst = {dst[23:0], b};
      if (tcp_at != 0 && pos == tcp_at + TCP_DOFF_OFS) begin
        doff = b[7:4];
        if (doff < MIN_HDR_WORDS) hdr_ok = 1'b0;
        else payload_at = tcp_at + 16'(doff) * 16'd4;
      end
    endfunction

    function void note_byte(input logic [7:0] b, input logic last, input logic [63:0] t);
      http_record_t r;
      if (pos == 0) stamp = t;
      if (hdr_ok) begin
        if (phase == SCAN_HEADER && payload_at != 0 && pos == payload_at) phase = SCAN_METHOD;
        case (phase)
          SCAN_HEADER: header_byte(b);
          SCAN_METHOD: begin
            if (n_method < METHOD_CHARS - 1 && b != CH_SPACE) begin
              method_chars[n_method] = b;
              n_method++;
            end else phase = SCAN_PATH;
          end
          SCAN_PATH: begin
            if (n_path < PATH_CHARS - 1 && b != CH_SPACE && b != CH_NUL) begin
              path_chars[n_path] = b;
              n_path++;
            end else begin
              phase = SCAN_VERSION;
              tag_matched = '0;
            end
          end
          SCAN_VERSION: begin
            if (b != VERSION_TAG[31 - 8 * tag_matched[1:0] -: 8]) hdr_ok = 1'b0;
            else begin
              tag_matched++;
              if (tag_matched >= 4) phase = SCAN_DONE;
            end
          end
          default: ;
        endcase
      end
      if (last) begin
        if (hdr_ok && phase == SCAN_DONE) begin
          for (int k = 0; k < NUM_RECORDS; k++) begin
            r.src = src;
            r.dst = dst;
            r.stamp = stamp;
            r.index = 3'(k);
            r.method = '0;
            r.path = '0;
            for (int c = 0; c < 8; c++) begin
              r.method = {r.method[55:0],
                          (8 * k + c < n_method) ? method_chars[8 * k + c] : 8'h00};
              r.path = {r.path[55:0], (8 * k + c < n_path) ? path_chars[8 * k + c] : 8'h00};
            end
            r.last = (k == NUM_RECORDS - 1);
            expected_records.push_back(r);
            records_predicted++;
          end
        end
        clear_frame();
      end else if (pos != 16'hFFFF) begin
        pos++;
      end
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_record(input logic [263:0] d, input logic last);
      http_record_t e;
      string bad;
      records_checked++;
      if (expected_records.size() == 0) begin
        report($sformatf("record %0d with nothing expected: %h", records_checked, d));
        return;
      end
      e = expected_records.pop_front();
      bad = "";
      if (d[31:0] !== e.src) bad = {bad, " src"};
      if (d[63:32] !== e.dst) bad = {bad, " dst"};
      if (d[127:64] !== e.stamp) bad = {bad, " stamp"};
      if (d[130:128] !== e.index) bad = {bad, " index"};
      if (d[194:131] !== e.method) bad = {bad, " method"};
      if (d[258:195] !== e.path) bad = {bad, " path"};
      if (last !== e.last) bad = {bad, " last"};
      if (bad != "")
        report($sformatf("record %0d bad%s: got %h/%b exp %h %h %h %0d %h %h %b",
                         records_checked, bad, d, last, e.src, e.dst, e.stamp,
                         e.index, e.method, e.path, e.last));
    endtask

    function int unsigned pending();
      return expected_records.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;   // pkt_byte[7:0], arrival_time[71:8]
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [263:0] out_tdata;       // src, dst, stamp, chunk_index, method, path, pad
  logic         out_tlast;

  int unsigned cyc = 0;
  int unsigned bytes_sent = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [7:0]  frame[$];
  request_line_scoreboard sb = new();

  http_request_line_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // no random idling on either side inside this window
  function automatic bit calm();
    return cyc >= 600 && cyc < 1800;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_record(out_tdata, out_tlast);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && sb.records_checked >= 10) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("http_request_line_extractor_tb: errors");
    $finish;
  end

  function automatic logic [7:0] text_char(input bit allow_nul);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_SPACE || (!allow_nul && c == CH_NUL));
    return c;
  endfunction

  function automatic void build_request(input int ihl, input int doff, input int n_meth,
                                        input logic [7:0] sep1, input int n_path,
                                        input logic [7:0] sep2, input int n_tail);
    int tcp_at;
    tcp_at = 14 + 4 * ihl;
    frame.delete();
    for (int i = 0; i < tcp_at + 4 * doff; i++) frame.push_back(8'($urandom));
    frame[POS_TYPE_HI] = ETH_TYPE_IP[15:8];
    frame[POS_TYPE_LO] = ETH_TYPE_IP[7:0];
    frame[POS_IHL] = {frame[POS_IHL][7:4], 4'(ihl)};
    frame[POS_PROTO] = IP_PROTO_TCP;
    frame[tcp_at + TCP_DOFF_OFS] = {4'(doff), frame[tcp_at + TCP_DOFF_OFS][3:0]};
    repeat (n_meth) frame.push_back(text_char(1'b1));
    frame.push_back(sep1);
    repeat (n_path) frame.push_back(text_char(1'b0));
    frame.push_back(sep2);
    for (int i = 0; i < 4; i++) frame.push_back(VERSION_TAG[31 - 8 * i -: 8]);
    repeat (n_tail) frame.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] t);
    while (!calm() && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t, b};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, last, t);
  endtask

  task automatic send_frame(input logic [63:0] t);
    for (int i = 0; i < frame.size(); i++)
      send_byte(frame[i], i == frame.size() - 1, i == 0 ? t : {$urandom, $urandom});
    bytes_sent += frame.size();
  endtask

  task automatic random_frame();
    int kind, ihl, doff, n_meth, n_path, n;
    logic [7:0] sep1, sep2;
    kind = $urandom_range(99);
    ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    doff = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    n_meth = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(7, 3);
    n_path = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(12);
    sep1 = (n_meth == METHOD_CHARS - 1 && $urandom_range(1)) ? text_char(1'b1) : CH_SPACE;
    if (n_path == PATH_CHARS - 1 && $urandom_range(1)) sep2 = text_char(1'b0);
    else sep2 = ($urandom_range(3) == 0) ? CH_NUL : CH_SPACE;
    build_request(ihl, doff, n_meth, sep1, n_path, sep2, $urandom_range(6));
    if (kind < 65) begin
    end else if (kind < 80) begin
      frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
    end else if (kind < 90) begin
      n = $urandom_range(frame.size() - 1, 1);
      frame = frame[0:n - 1];
    end else begin
      frame.delete();
      repeat ($urandom_range(90, 1)) frame.push_back(8'($urandom));
    end
    send_frame({$urandom, $urandom});
  endtask

  initial begin
    int unsigned start_bytes, start_recs;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // accepted, bar the overlong method: time, header size, name length extremes
    build_request(5, 5, 3, CH_SPACE, 1, CH_SPACE, 0);
    send_frame('0);
    build_request(15, 15, 4, CH_SPACE, 9, CH_NUL, 0);
    send_frame('1);
    build_request(5, 5, METHOD_CHARS - 1, text_char(1'b1), PATH_CHARS - 1,
                  text_char(1'b0), 3);
    send_frame({$urandom, $urandom});
    build_request(6, 9, 0, CH_SPACE, 0, CH_SPACE, 0);
    send_frame({$urandom, $urandom});
    build_request(5, 5, 20, CH_SPACE, 5, CH_SPACE, 2);
    send_frame({$urandom, $urandom});
    build_request(7, 5, 5, CH_SPACE, 7, CH_SPACE, 20);
    send_frame({$urandom, $urandom});

    // rejected frames
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[POS_TYPE_HI] = 8'h86;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[POS_TYPE_LO] = 8'hDD;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[POS_PROTO] = 8'd17;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[POS_IHL] = 8'h44;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[POS_IHL] = 8'h40;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[34 + TCP_DOFF_OFS] = 8'h4F;
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame = frame[0:29];
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame = frame[0:frame.size() - 3];
    send_frame({$urandom, $urandom});
    build_request(5, 5, 3, CH_SPACE, 4, CH_SPACE, 0);
    frame[frame.size() - 1] = 8'h58;
    send_frame({$urandom, $urandom});
    frame.delete();
    frame.push_back(8'h00);
    send_frame({$urandom, $urandom});

    start_bytes = bytes_sent;
    start_recs = sb.records_predicted;
    while (bytes_sent - start_bytes < 460 || sb.records_predicted - start_recs < 48)
      random_frame();

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("http_request_line_extractor_tb: clean");
    end else begin
      $display("http_request_line_extractor_tb: errors");
    end
    $finish;
  end

endmodule
